// ===== rtl/utf8_stream_decoder_top_macros.svh =====
// Assertion helpers for the UTF-8 stream decoder.
`ifndef UTF8_STREAM_DECODER_TOP_MACROS_SVH
`define UTF8_STREAM_DECODER_TOP_MACROS_SVH

// Same-cycle implication, gated by the active-low reset.
`define U8D_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("u8d: same-cycle check failed");

// Next-cycle implication, gated by the active-low reset.
`define U8D_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("u8d: next-cycle check failed");

`endif

// ===== rtl/u8d_pkg.sv =====
package u8d_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 16;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;
  localparam int unsigned CP_W            = 21;
  localparam int unsigned OUT_CNT_W       = 16;

  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_NUL,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_CONT,
    CLS_BAD
  } byte_cls_e;

  typedef enum logic [2:0] {
    KIND_CHAR     = 3'd0,
    KIND_BAD_LEAD = 3'd1,
    KIND_BAD_CONT = 3'd2,
    KIND_TRUNC    = 3'd3,
    KIND_NUL      = 3'd4
  } kind_e;

  // classified byte, front to back
  typedef struct packed {
    logic [7:0] data;
    byte_cls_e  cls;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [CP_W-1:0]      code_point;
    logic [2:0]           char_length;
    kind_e                kind;
    logic [OUT_CNT_W-1:0] valid_bytes;
    logic [OUT_CNT_W-1:0] valid_chars;
    logic                 last;
  } result_t;

endpackage

// ===== rtl/u8d_fifo.sv =====
module u8d_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push_ok, pop_ok;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign push_ok = push_i & ~full_o;
  assign pop_ok  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_ok ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_ok ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_ok && !pop_ok) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_ok && !push_ok) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/u8d_front.sv =====
module u8d_front
  import u8d_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic       cfg_stop_on_nul_i,
  input  logic [7:0] byte_in_i,
  input  logic       end_of_buffer_i,
  output item_t      item_o
);

  logic      stop_on_nul_q;
  byte_cls_e cls;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_on_nul_q <= 1'b1;
    end else if (cfg_valid_i) begin
      stop_on_nul_q <= cfg_stop_on_nul_i;
    end
  end

  // byte-class pattern match; no decode state, only the stop_on_nul setting
  always_comb begin
    priority if (byte_in_i == 8'h00 && stop_on_nul_q) begin
      cls = CLS_NUL;
    end else if (byte_in_i[7] == 1'b0) begin
      cls = CLS_ASCII;
    end else if (byte_in_i[7:6] == 2'b10) begin
      cls = CLS_CONT;
    end else if (byte_in_i[7:5] == 3'b110) begin
      cls = CLS_LEAD2;
    end else if (byte_in_i[7:4] == 4'b1110) begin
      cls = CLS_LEAD3;
    end else if (byte_in_i[7:3] == 5'b11110) begin
      cls = CLS_LEAD4;
    end else begin
      cls = CLS_BAD;
    end
  end

  assign item_o = '{data: byte_in_i, cls: cls, last: end_of_buffer_i};

endmodule

// ===== rtl/u8d_back.sv =====
`include "utf8_stream_decoder_top_macros.svh"

module u8d_back
  import u8d_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  item_t   item_i,
  output logic    in_pop_o,
  input  logic    res_ready_i,
  output logic    res_push_o,
  output result_t res_o
);

  localparam int unsigned SumW = COUNT_WIDTH + 1;
  localparam logic [COUNT_WIDTH-1:0] CntMax = {COUNT_WIDTH{1'b1}};

  logic [1:0]             pend_q, pend_d;
  logic [2:0]             seq_len_q, seq_len_d;
  logic [CP_W-1:0]        part_q, part_d;
  logic [COUNT_WIDTH-1:0] byte_tot_q, byte_tot_d;
  logic [COUNT_WIDTH-1:0] char_tot_q, char_tot_d;
  logic                   halted_q, halted_d;

  logic                   go;
  kind_e                  kind;
  logic [CP_W-1:0]        cp, part_shift;
  logic [2:0]             len;
  logic                   emit;
  logic [SumW-1:0]        byte_sum, char_sum;
  logic [COUNT_WIDTH-1:0] byte_upd, char_upd;

  assign go         = in_valid_i & res_ready_i;
  assign in_pop_o   = go;
  assign part_shift = {part_q[CP_W-7:0], item_i.data[5:0]};

  // decode step
  always_comb begin
    pend_d    = pend_q;
    seq_len_d = seq_len_q;
    part_d    = part_q;
    kind      = KIND_TRUNC;
    cp        = '0;
    len       = '0;
    if (pend_q == 2'd0) begin
      unique case (item_i.cls)
        CLS_NUL:   kind = KIND_NUL;
        CLS_ASCII: begin
          kind = KIND_CHAR;
          cp   = CP_W'(item_i.data);
          len  = 3'd1;
        end
        CLS_LEAD2: begin
          seq_len_d = 3'd2;
          pend_d    = 2'd1;
          part_d    = CP_W'(item_i.data[4:0]);
        end
        CLS_LEAD3: begin
          seq_len_d = 3'd3;
          pend_d    = 2'd2;
          part_d    = CP_W'(item_i.data[3:0]);
        end
        CLS_LEAD4: begin
          seq_len_d = 3'd4;
          pend_d    = 2'd3;
          part_d    = CP_W'(item_i.data[2:0]);
        end
        default:   kind = KIND_BAD_LEAD;
      endcase
    end else if (item_i.cls != CLS_CONT) begin
      kind = KIND_BAD_CONT;
    end else begin
      pend_d = pend_q - 2'd1;
      part_d = part_shift;
      if (pend_q == 2'd1) begin
        kind      = KIND_CHAR;
        cp        = part_shift;
        len       = seq_len_q;
        seq_len_d = '0;
        part_d    = '0;
      end
    end
    emit = ~halted_q & ~((kind == KIND_TRUNC) & ~item_i.last);
  end

  // saturating totals
  always_comb begin
    byte_sum = {1'b0, byte_tot_q} + SumW'(len);
    char_sum = {1'b0, char_tot_q} + SumW'(1);
    byte_upd = byte_tot_q;
    char_upd = char_tot_q;
    if (kind == KIND_CHAR) begin
      byte_upd = byte_sum[COUNT_WIDTH] ? CntMax : byte_sum[COUNT_WIDTH-1:0];
      char_upd = char_sum[COUNT_WIDTH] ? CntMax : char_sum[COUNT_WIDTH-1:0];
    end
  end

  always_comb begin
    halted_d   = halted_q;
    byte_tot_d = byte_tot_q;
    char_tot_d = char_tot_q;
    if (go) begin
      if (item_i.last) begin
        halted_d   = 1'b0;
        byte_tot_d = '0;
        char_tot_d = '0;
      end else if (!halted_q) begin
        byte_tot_d = byte_upd;
        char_tot_d = char_upd;
        halted_d   = emit & (kind != KIND_CHAR);
      end
    end
  end

  assign res_push_o = go & emit;

  always_comb begin
    res_o.code_point  = cp;
    res_o.char_length = len;
    res_o.kind        = kind;
    res_o.valid_bytes = OUT_CNT_W'(byte_upd);
    res_o.valid_chars = OUT_CNT_W'(char_upd);
    res_o.last        = item_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q     <= '0;
      seq_len_q  <= '0;
      part_q     <= '0;
      byte_tot_q <= '0;
      char_tot_q <= '0;
      halted_q   <= 1'b0;
    end else begin
      byte_tot_q <= byte_tot_d;
      char_tot_q <= char_tot_d;
      halted_q   <= halted_d;
      if (go && (item_i.last || halted_q)) begin
        // end of buffer clears; halted bytes never start a sequence
        if (item_i.last) begin
          pend_q    <= '0;
          seq_len_q <= '0;
          part_q    <= '0;
        end
      end else if (go) begin
        pend_q    <= pend_d;
        seq_len_q <= seq_len_d;
        part_q    <= part_d;
      end
    end
  end

  `U8D_ASSERT_IMPL(a_halt_quiet, clk_i, rst_ni, halted_q, !res_push_o)
  `U8D_ASSERT_IMPL(a_seq_open, clk_i, rst_ni, pend_q != 2'd0, seq_len_q > {1'b0, pend_q})
  `U8D_ASSERT_NEXT(a_eob_clear, clk_i, rst_ni, go && item_i.last,
                   byte_tot_q == '0 && char_tot_q == '0 && !halted_q && pend_q == 2'd0)
  `U8D_ASSERT_IMPL(a_char_len, clk_i, rst_ni, res_push_o && res_o.kind == KIND_CHAR,
                   res_o.char_length != 3'd0)

endmodule

// ===== rtl/utf8_stream_decoder_top.sv =====
// UTF-8 stream decoder and validator.
// Input: one buffer word (byte_in_i, end_of_buffer_i) is taken on each clock edge
//   with push high and full low. end_of_buffer_i flags the buffer's last byte.
// Output: while empty is low the oldest result sits on the result ports; it is
//   taken on an edge with pop high. A result is a decoded character (kind 0) or
//   an error / terminator report with running saturating byte and char totals.
// Configuration: cfg_stop_on_nul_i is written on cfg_valid_i (cfg_ready_o is
//   always high); write only while the block is idle.
// Throughput: one byte per cycle while the output queue has room, set by the
//   combinational decode step in the back end. Path: an accepted byte sits
//   in the middle queue, then its result (if any) in the output queue.
// Structure: the front end classifies each byte and pushes it to a short queue;
//   the back end pops it, runs the sequence state and counters, and pushes
//   results into an output queue. A stalled receiver fills the output queue,
//   then the middle queue, then full rises; nothing is dropped.
// Reset: queues empty, decode state and totals cleared, stop_on_nul set to 1.
module utf8_stream_decoder_top
  import u8d_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_stop_on_nul_i,
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           byte_in_i,
  input  logic                 end_of_buffer_i,
  input  logic                 pop,
  output logic                 empty,
  output logic [CP_W-1:0]      code_point_o,
  output logic [2:0]           char_length_o,
  output logic [2:0]           kind_o,
  output logic [OUT_CNT_W-1:0] valid_bytes_o,
  output logic [OUT_CNT_W-1:0] valid_chars_o,
  output logic                 last_result_o
);

  item_t   front_item, mid_item;
  logic    mid_empty, mid_pop;
  logic    res_push, res_full;
  result_t res_in, res_out;

  assign cfg_ready_o = 1'b1;

  u8d_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_stop_on_nul_i (cfg_stop_on_nul_i),
    .byte_in_i         (byte_in_i),
    .end_of_buffer_i   (end_of_buffer_i),
    .item_o            (front_item)
  );

  // classified bytes waiting for the decode stage
  u8d_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_item),
    .full_o  (full),
    .pop_i   (mid_pop),
    .data_o  (mid_item),
    .empty_o (mid_empty)
  );

  u8d_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (~mid_empty),
    .item_i      (mid_item),
    .in_pop_o    (mid_pop),
    .res_ready_i (~res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // finished results; decouples decode from the receiver
  u8d_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign code_point_o  = res_out.code_point;
  assign char_length_o = res_out.char_length;
  assign kind_o        = res_out.kind;
  assign valid_bytes_o = res_out.valid_bytes;
  assign valid_chars_o = res_out.valid_chars;
  assign last_result_o = res_out.last;

endmodule

// ===== tb/utf8_decode_tb_pkg.sv =====
package utf8_decode_tb_pkg;
  import u8d_pkg::*;

  localparam int unsigned TOTAL_MAX = (1 << COUNT_WIDTH_DEF) - 1;

  // Predicts decoder results and checks the words popped from the block.
  class utf8_decode_scoreboard;
    bit               stop_on_nul;
    logic [1:0]       cont_due;
    logic [2:0]       seq_len;
    logic [CP_W-1:0]  partial;
    int unsigned      byte_total;
    int unsigned      char_total;
    bit               halted;
    result_t          expected_q[$];
    int unsigned      fail_count;

    function new();
      stop_on_nul = 1'b1;
      fail_count  = 0;
      clear_decode();
    endfunction

    function void clear_decode();
      cont_due   = '0;
      seq_len    = '0;
      partial    = '0;
      byte_total = 0;
      char_total = 0;
      halted     = 1'b0;
    endfunction

    function void set_stop_on_nul(bit v);
      stop_on_nul = v;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // One accepted input word: update state, queue a result if one is due.
    function void note_word(logic [7:0] b, logic last);
      result_t         r;
      kind_e           k;
      logic [CP_W-1:0] cp;
      logic [2:0]      len;
      cp  = '0;
      len = '0;
      if (halted) begin
        if (last) clear_decode();
        return;
      end
      if (cont_due == 2'd0) begin
        if (b == 8'h00 && stop_on_nul) begin
          k = KIND_NUL;
        end else if (!b[7]) begin
          k   = KIND_CHAR;
          cp  = CP_W'(b);
          len = 3'd1;
        end else if (b[7:5] == 3'b110) begin
          seq_len = 3'd2; cont_due = 2'd1; partial = CP_W'(b[4:0]); k = KIND_TRUNC;
        end else if (b[7:4] == 4'b1110) begin
          seq_len = 3'd3; cont_due = 2'd2; partial = CP_W'(b[3:0]); k = KIND_TRUNC;
        end else if (b[7:3] == 5'b11110) begin
          seq_len = 3'd4; cont_due = 2'd3; partial = CP_W'(b[2:0]); k = KIND_TRUNC;
        end else begin
          k = KIND_BAD_LEAD;
        end
      end else if (b[7:6] != 2'b10) begin
        k = KIND_BAD_CONT;
      end else begin
        partial  = {partial[CP_W-7:0], b[5:0]};
        cont_due = cont_due - 2'd1;
        if (cont_due == 2'd0) begin
          k       = KIND_CHAR;
          cp      = partial;
          len     = seq_len;
          seq_len = '0;
          partial = '0;
        end else begin
          k = KIND_TRUNC;
        end
      end
      if (k == KIND_TRUNC && !last) return;
      if (k == KIND_CHAR) begin
        byte_total = (byte_total + len > TOTAL_MAX) ? TOTAL_MAX : byte_total + len;
        char_total = (char_total + 1 > TOTAL_MAX) ? TOTAL_MAX : char_total + 1;
      end
      r.code_point  = cp;
      r.char_length = len;
      r.kind        = k;
      r.valid_bytes = OUT_CNT_W'(byte_total);
      r.valid_chars = OUT_CNT_W'(char_total);
      r.last        = last;
      expected_q.push_back(r);
      if (last) clear_decode();
      else if (k != KIND_CHAR) halted = 1'b1;
    endfunction

    function void cmp_field(string name, int unsigned exp, int unsigned act);
      if (exp != act) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
        fail_count++;
      end
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected: kind %0d", got.kind);
        fail_count++;
        return;
      end
      exp = expected_q.pop_front();
      cmp_field("code_point",  exp.code_point,  got.code_point);
      cmp_field("char_length", exp.char_length, got.char_length);
      cmp_field("kind",        exp.kind,        got.kind);
      cmp_field("valid_bytes", exp.valid_bytes, got.valid_bytes);
      cmp_field("valid_chars", exp.valid_chars, got.valid_chars);
      cmp_field("last_result", exp.last,        got.last);
    endfunction
  endclass

endpackage

// ===== tb/utf8_stream_decoder_top_test.sv =====
module utf8_stream_decoder_top_test;
  import u8d_pkg::*;
  import utf8_decode_tb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Cycles to let a word with no result clear the pipeline before a
  // register write or the end check (decode latency plus queue slack).
  localparam int SETTLE_CYCLES = 8;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 cfg_valid       = 1'b0;
  logic                 cfg_ready;
  logic                 cfg_stop_on_nul = 1'b1;
  logic                 push            = 1'b0;
  logic                 full;
  logic [7:0]           byte_in         = 8'h00;
  logic                 end_of_buffer   = 1'b0;
  logic                 pop             = 1'b0;
  logic                 empty;
  logic [CP_W-1:0]      code_point;
  logic [2:0]           char_length;
  logic [2:0]           kind;
  logic [OUT_CNT_W-1:0] valid_bytes;
  logic [OUT_CNT_W-1:0] valid_chars;
  logic                 last_result;

  utf8_decode_scoreboard sb;

  // Sender burst state and word count
  int          burst_left  = 0;
  int          words_sent  = 0;
  // Receiver stall pattern state
  int          rx_mode     = 0;
  int unsigned rx_mode_left = 0;

  // Buffer being assembled for sending; end flag goes on its last byte
  logic [7:0]  seq_q[$];

  utf8_stream_decoder_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_stop_on_nul_i (cfg_stop_on_nul),
    .push              (push),
    .full              (full),
    .byte_in_i         (byte_in),
    .end_of_buffer_i   (end_of_buffer),
    .pop               (pop),
    .empty             (empty),
    .code_point_o      (code_point),
    .char_length_o     (char_length),
    .kind_o            (kind),
    .valid_bytes_o     (valid_bytes),
    .valid_chars_o     (valid_chars),
    .last_result_o     (last_result)
  );

  always begin
    #5ns clk_i = 1'b1;
    #5ns clk_i = 1'b0;
  end

  // Receiver: switches between free-running, light stalls, heavy stalls and
  // a fixed on/off rhythm, each held for a random stretch of cycles.
  always @(posedge clk_i) begin
    if (rx_mode_left == 0) begin
      rx_mode      <= $urandom_range(0, 3);
      rx_mode_left <= $urandom_range(16, 200);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    case (rx_mode)
      0:       pop <= 1'b1;
      1:       pop <= ($urandom_range(0, 3) != 0);
      2:       pop <= ($urandom_range(0, 3) == 0);
      default: pop <= rx_mode_left[3];
    endcase
  end

  // Sample every handshake on the clock edge, before the block updates.
  // Register writes and input words go to the predictor; popped words
  // are checked against the oldest expectation.
  always @(posedge clk_i) begin : watch_ports
    result_t got;
    if (rst_ni) begin
      if (cfg_valid && cfg_ready) sb.set_stop_on_nul(cfg_stop_on_nul);
      if (push && !full) sb.note_word(byte_in, end_of_buffer);
      if (pop && !empty) begin
        got.code_point  = code_point;
        got.char_length = char_length;
        got.kind        = kind_e'(kind);
        got.valid_bytes = valid_bytes;
        got.valid_chars = valid_chars;
        got.last        = last_result;
        sb.check_result(got);
      end
    end
  end

  // One input word. A fresh burst may open with a random gap; push stays
  // high across back-to-back words so it is never dropped and raised in
  // one step.
  task automatic send_word(input logic [7:0] b, input logic eob);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 12);
    end
    burst_left--;
    push          <= 1'b1;
    byte_in       <= b;
    end_of_buffer <= eob;
    do @(posedge clk_i); while (full);
    words_sent++;
  endtask

  task automatic send_seq();
    foreach (seq_q[i]) send_word(seq_q[i], i == seq_q.size() - 1);
  endtask

  // Stop sending and wait until every expected word has been popped, then
  // give any result-less word time to leave the block.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_stop_on_nul(input logic v);
    cfg_valid       <= 1'b1;
    cfg_stop_on_nul <= v;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed buffers of random characters; the rest corrupted
  // (stray byte, cut short, overwritten byte) or plain noise.
  task automatic send_random_buffer();
    int          n_chars;
    int          len;
    int          shape;
    logic [31:0] r;
    seq_q   = {};
    n_chars = $urandom_range(1, 10);
    for (int c = 0; c < n_chars; c++) begin
      len = $urandom_range(1, 4);
      r   = $urandom;
      case (len)
        1: seq_q.push_back({1'b0, r[6:0]});
        2: begin
          seq_q.push_back({3'b110, r[4:0]});
          seq_q.push_back({2'b10, r[10:5]});
        end
        3: begin
          seq_q.push_back({4'b1110, r[3:0]});
          seq_q.push_back({2'b10, r[9:4]});
          seq_q.push_back({2'b10, r[15:10]});
        end
        default: begin
          seq_q.push_back({5'b11110, r[2:0]});
          seq_q.push_back({2'b10, r[8:3]});
          seq_q.push_back({2'b10, r[14:9]});
          seq_q.push_back({2'b10, r[20:15]});
        end
      endcase
    end
    shape = $urandom_range(0, 9);
    case (shape)
      0: seq_q[$urandom_range(0, seq_q.size() - 1)] = 8'($urandom);
      1: if (seq_q.size() > 1) void'(seq_q.pop_back());
      2: seq_q.insert($urandom_range(0, seq_q.size()), 8'($urandom));
      3: begin
        seq_q = {};
        repeat ($urandom_range(1, 6)) seq_q.push_back(8'($urandom));
      end
      default: ;
    endcase
    send_seq();
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words, terminator enabled (reset value).
    seq_q = {8'h41, 8'h7F, 8'h00};          // ASCII, then NUL on the end byte
    send_seq();
    seq_q = {8'h00, 8'h41, 8'h42};          // NUL mid-buffer, rest dropped
    send_seq();
    // two-, three- and four-byte characters, the last one all ones
    seq_q = {8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80,
             8'hF7, 8'hBF, 8'hBF, 8'hBF};
    send_seq();
    seq_q = {8'h80, 8'h41};                 // continuation with no lead
    send_seq();
    seq_q = {8'hFF};                        // bad lead on the end byte
    send_seq();
    seq_q = {8'hC3, 8'h41, 8'h42};          // bad continuation
    send_seq();
    seq_q = {8'hE2, 8'h82};                 // cut short by the end byte
    send_seq();
    seq_q = {8'hF0};                        // lone lead on the end byte
    send_seq();
    drain();

    // Zero bytes become plain characters.
    write_stop_on_nul(1'b0);
    seq_q = {8'h00, 8'h00};
    send_seq();

    while (words_sent < 350) send_random_buffer();
    drain();

    write_stop_on_nul(1'b1);
    while (words_sent < 690) send_random_buffer();
    drain();

    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("** utf8_stream_decoder_top: PASSED **");
    end else begin
      $display("** utf8_stream_decoder_top: FAILED **");
    end
    $finish;
  end

  // Watchdog, well past the slowest legal run
  initial begin
    #12ms;
    $display("** utf8_stream_decoder_top: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/u8d_pkg.sv
rtl/u8d_fifo.sv
rtl/u8d_front.sv
rtl/u8d_back.sv
rtl/utf8_stream_decoder_top.sv
tb/utf8_decode_tb_pkg.sv
tb/utf8_stream_decoder_top_test.sv
